// ----- rtl/core/zczc_nnnn_bulletin_deframer_core_defines.svh -----
// Assertion macros used by the deframer core.
`ifndef ZCZC_NNNN_BULLETIN_DEFRAMER_CORE_DEFINES_SVH
`define ZCZC_NNNN_BULLETIN_DEFRAMER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ZNBD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("znbd assertion failed");

// Next-cycle implication.
`define ZNBD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("znbd assertion failed");

`else

`define ZNBD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ZNBD_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/znbd_pkg.sv -----
package znbd_pkg;

   // marker geometry
   localparam int MarkLen = 6;
   localparam int QueueDepthDefault = 4;

   localparam logic [7:0] CharCr = 8'h0D;

   // start marker ZCZC CR LF and its fallback table
   localparam logic [7:0] StartMark [MarkLen] =
      '{8'h5A, 8'h43, 8'h5A, 8'h43, 8'h0D, 8'h0A};
   localparam logic [2:0] StartFail [MarkLen] =
      '{3'd0, 3'd0, 3'd1, 3'd2, 3'd0, 3'd0};

   // end marker CR LF NNNN
   localparam logic [7:0] EndMark [MarkLen] =
      '{8'h0D, 8'h0A, 8'h4E, 8'h4E, 8'h4E, 8'h4E};

   typedef logic [2:0] prog_type;

   typedef enum logic {
      KindPayload = 1'b0,
      KindEnd     = 1'b1
   } kind_type;

   // one queued job: withheld prefix to release, then byte or end mark
   typedef struct packed {
      logic       is_end;
      prog_type   rel_count;
      logic       has_byte;
      logic [7:0] data;
   } cmd_type;

   // start marker matcher step with prefix fallback
   function automatic prog_type start_step(prog_type p, logic [7:0] b);
      prog_type q;
      q = (p >= prog_type'(MarkLen)) ? '0 : p;
      for (int k = 0; k < MarkLen - 1; k++) begin
         if (q != '0 && b != StartMark[q]) begin
            q = StartFail[q - 3'd1];
         end
      end
      if (b == StartMark[q]) begin
         q = q + 3'd1;
      end
      return q;
   endfunction

endpackage

// ----- rtl/core/znbd_front.sv -----
module znbd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_in_byte,
   input  logic              q_full,
   output logic              push_valid,
   output znbd_pkg::cmd_type push_cmd
);

   logic               in_body_ff, in_body_in;
   znbd_pkg::prog_type start_prog_ff, start_prog_in;
   znbd_pkg::prog_type end_prog_ff, end_prog_in;
   znbd_pkg::prog_type start_nxt;
   znbd_pkg::prog_type end_p;
   logic               accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign start_nxt = znbd_pkg::start_step(start_prog_ff, req_in_byte);
   assign end_p     = (end_prog_ff >= znbd_pkg::prog_type'(znbd_pkg::MarkLen)) ?
                      '0 : end_prog_ff;

   // classify the word and build the job for the back end
   always_comb begin
      in_body_in    = in_body_ff;
      start_prog_in = start_prog_ff;
      end_prog_in   = end_prog_ff;
      push_valid    = 1'b0;
      push_cmd      = '0;
      if (accept) begin
         if (!in_body_ff) begin
            if (start_nxt == znbd_pkg::prog_type'(znbd_pkg::MarkLen)) begin
               in_body_in    = 1'b1;
               start_prog_in = '0;
               end_prog_in   = '0;
            end else begin
               start_prog_in = start_nxt;
            end
         end else if (req_in_byte == znbd_pkg::EndMark[end_p]) begin
            if (end_p == znbd_pkg::prog_type'(znbd_pkg::MarkLen - 1)) begin
               push_valid      = 1'b1;
               push_cmd.is_end = 1'b1;
               in_body_in      = 1'b0;
               start_prog_in   = '0;
               end_prog_in     = '0;
            end else begin
               end_prog_in = end_p + 3'd1;
            end
         end else begin
            // mismatch: release withheld prefix, then handle this word afresh
            push_cmd.rel_count = end_p;
            if (req_in_byte == znbd_pkg::CharCr) begin
               end_prog_in = 3'd1;
               push_valid  = (end_p != '0);
            end else begin
               end_prog_in       = '0;
               push_valid        = 1'b1;
               push_cmd.has_byte = 1'b1;
               push_cmd.data     = req_in_byte;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_body_ff    <= 1'b0;
         start_prog_ff <= '0;
         end_prog_ff   <= '0;
      end else begin
         in_body_ff    <= in_body_in;
         start_prog_ff <= start_prog_in;
         end_prog_ff   <= end_prog_in;
      end
   end

endmodule

// ----- rtl/core/znbd_queue.sv -----
module znbd_queue #(
   parameter int Depth = znbd_pkg::QueueDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  znbd_pkg::cmd_type push_cmd,
   output logic              q_full,
   output logic              q_valid,
   output znbd_pkg::cmd_type q_cmd,
   input  logic              q_pop
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   znbd_pkg::cmd_type entry_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign q_full  = (count_ff == CntW'(Depth));
   assign q_valid = (count_ff != '0);
   assign q_cmd   = entry_ff[rd_ptr_ff];
   assign do_push = push_valid && !q_full;
   assign do_pop  = q_pop && q_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- rtl/core/znbd_back.sv -----
module znbd_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  znbd_pkg::cmd_type q_cmd,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_out_kind,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_run_last
);

   logic               rsp_valid_ff, rsp_valid_in;
   logic               kind_ff, kind_in;
   logic [7:0]         byte_ff, byte_in;
   logic               last_ff, last_in;
   znbd_pkg::prog_type idx_ff, idx_in;
   znbd_pkg::prog_type total;
   logic               load;

   assign load  = q_valid && (!rsp_valid_ff || rsp_ready);
   assign total = q_cmd.rel_count + {2'b00, (q_cmd.is_end || q_cmd.has_byte)};

   // expand the head job into one result word per cycle while the output word is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_in      = kind_ff;
      byte_in      = byte_ff;
      last_in      = last_ff;
      idx_in       = idx_ff;
      q_pop        = 1'b0;
      if (load) begin
         rsp_valid_in = 1'b1;
         last_in      = (idx_ff == total - 3'd1);
         if (idx_ff < q_cmd.rel_count) begin
            kind_in = znbd_pkg::KindPayload;
            byte_in = znbd_pkg::EndMark[idx_ff];
         end else if (q_cmd.is_end) begin
            kind_in = znbd_pkg::KindEnd;
            byte_in = '0;
         end else begin
            kind_in = znbd_pkg::KindPayload;
            byte_in = q_cmd.data;
         end
         if (last_in) begin
            q_pop  = 1'b1;
            idx_in = '0;
         end else begin
            idx_in = idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_kind = kind_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_run_last = last_ff;

endmodule

// ----- rtl/core/zczc_nnnn_bulletin_deframer_core.sv -----
// Bulletin deframer: pulls messages framed by ZCZC CR LF ... CR LF NNNN out
// of a byte stream.
// Input channel req_*: one received byte per word (req_in_byte).
// Result channel rsp_*: payload words (rsp_out_kind 0, rsp_out_byte) and one
// end-of-message word (rsp_out_kind 1, byte 0) per message; rsp_run_last
// marks the last result word caused by an input byte.
// Bytes outside a message and the bytes of the start marker give no result;
// the byte that completes the end marker gives the end-of-message word.
// Bytes that may begin the end marker are held back and released in order
// when the match breaks, so one input byte gives up to six result words.
// A byte's job is written into the job queue when the byte is accepted, and
// its first result word is loaded from the queue into the output register.
// Throughput: one byte per cycle; a byte that gives n result words passes
// them through the single-word output register one by one, and the front
// keeps accepting until the job queue (QueueDepth jobs) fills.
// When rsp_ready is low the output word holds and the queue absorbs further
// jobs; req_ready drops only when the queue is full.
// Reset (synchronous, active high) returns to hunting for the start marker
// and empties the queue and the output register.
`include "zczc_nnnn_bulletin_deframer_core_defines.svh"

module zczc_nnnn_bulletin_deframer_core #(
   parameter int QueueDepth = znbd_pkg::QueueDepthDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_out_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last
);

   logic              q_full;
   logic              push_valid;
   znbd_pkg::cmd_type push_cmd;
   logic              q_valid;
   znbd_pkg::cmd_type q_cmd;
   logic              q_pop;

   // byte matcher and job builder
   znbd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .q_full      (q_full),
      .push_valid  (push_valid),
      .push_cmd    (push_cmd)
   );

   // job queue between front and back
   znbd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .q_full     (q_full),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop)
   );

   // result expansion and output register
   znbd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_cmd        (q_cmd),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_kind (rsp_out_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last)
   );

   // end of message is always the last word of its byte and carries zero
   `ZNBD_ASSERT_IMP(a_end_is_last, clock, reset, rsp_valid && rsp_out_kind, rsp_run_last)
   `ZNBD_ASSERT_IMP(a_end_byte_zero, clock, reset, rsp_valid && rsp_out_kind, rsp_out_byte == 8'h00)
   // front never pushes into a full queue
   `ZNBD_ASSERT_IMP(a_no_push_full, clock, reset, push_valid, !q_full)
   // a pop with no push beside it leaves a non-full queue behind
   `ZNBD_ASSERT_NXT(a_pop_frees, clock, reset, q_pop && !push_valid, !q_full)

endmodule
